@@ design/tccw_pkg.sv @@
// Shared types and constants for the text console cell writer.
`timescale 1ns / 1ps
package tccw_pkg;

  // Width of the comparison path for rows and columns (covers up to 256 columns).
  localparam int SPAN_W = 9;
  typedef logic [SPAN_W-1:0] span_t;

  // Item function codes.
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_MOVE  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Control bytes and the printable range.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7E;

  // Configuration register indexes and reset values.
  localparam logic       REG_WIDTH  = 1'b0;
  localparam logic       REG_HEIGHT = 1'b1;
  localparam logic [7:0] WIDTH_RST  = 8'd80;
  localparam logic [6:0] HEIGHT_RST = 7'd24;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_CLEAR,
    SW_COPY,
    SW_BLANK
  } sweep_state_t;

  typedef struct packed {
    logic start;
    logic scroll;
  } sweep_cmd_t;

  typedef struct packed {
    logic active;
    logic finish;
  } sweep_stat_t;

endpackage

@@ design/text_console_cell_writer_top.sv @@
// Top level of the character-cell text window: command decode, cursor and store.
`timescale 1ns / 1ps
// Usage
//   Issue a command by raising start while busy is low; func, char_code,
//   target_row, target_col and end_of_text are sampled at that edge.
//   Every command gives one transaction on the result side: done is high for
//   exactly one cycle with cursor_row, cursor_col, read_char, dropped and
//   write_done valid alongside it. The receiver cannot stall.
//   Put (other than an LF that scrolls), move and read: done follows in the
//   cycle after the command and busy stays low, so a new command may be
//   issued every cycle. LF on or below the last window row scrolls: the
//   store is walked one cell per cycle through the single write port, busy
//   high throughout. Clear walks every store entry (8192 at defaults).
//   Reset: cursor to home, registers to 80 columns by 24 rows, and a
//   clearing pass over the whole store runs with busy high and no done.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module text_console_cell_writer_top
  import tccw_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [7:0] char_code,
  input  logic [5:0] target_row,
  input  logic [6:0] target_col,
  input  logic       end_of_text,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output logic       done,
  output logic [5:0] cursor_row,
  output logic [7:0] cursor_col,
  output logic [7:0] read_char,
  output logic       dropped,
  output logic       write_done
);

  localparam int RB  = $clog2(MAX_ROWS);
  localparam int CB  = $clog2(MAX_COLS);
  localparam int CLW = $clog2(MAX_COLS + 1);
  localparam int AW  = RB + CB;

  logic [7:0]     width_reg;
  logic [6:0]     height_reg;
  logic [RB-1:0]  cur_row, cur_row_next;
  logic [CLW-1:0] cur_col, cur_col_next;
  logic           init_pass;
  logic           rd_flag;
  logic           done_next, dropped_next;

  span_t          w_eff, h_eff, trow_c, tcol_c, row_s, col_s;
  logic           acc, printable, lf_scroll, put_ok, put_we;
  sweep_cmd_t     cmd;
  sweep_stat_t    stat;
  logic [RB-1:0]  last_row;
  logic           sw_we;
  logic [AW-1:0]  sw_waddr, sw_raddr;
  logic [7:0]     sw_wdata;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  assign busy = stat.active;
  assign acc  = start && !busy;

  // effective window size
  always_comb begin
    if (width_reg == 8'd0) begin
      w_eff = span_t'(1);
    end else if (span_t'(width_reg) > span_t'(MAX_COLS)) begin
      w_eff = span_t'(MAX_COLS);
    end else begin
      w_eff = span_t'(width_reg);
    end
    if (height_reg == 7'd0) begin
      h_eff = span_t'(1);
    end else if (span_t'(height_reg) > span_t'(MAX_ROWS)) begin
      h_eff = span_t'(MAX_ROWS);
    end else begin
      h_eff = span_t'(height_reg);
    end
  end

  always_comb begin
    trow_c    = (span_t'(target_row) >= h_eff) ? h_eff - span_t'(1) : span_t'(target_row);
    tcol_c    = (span_t'(target_col) >= w_eff) ? w_eff - span_t'(1) : span_t'(target_col);
    row_s     = span_t'(cur_row);
    col_s     = span_t'(cur_col);
    printable = char_code inside {[CH_FIRST:CH_LAST]};
    lf_scroll = (row_s + span_t'(1) >= h_eff);
    put_ok    = (col_s < w_eff) && (row_s < h_eff);
    last_row  = RB'(h_eff - span_t'(1));
  end

  // command decode and cursor update
  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    dropped_next = dropped;
    put_we       = 1'b0;
    cmd.start    = 1'b0;
    cmd.scroll   = 1'b0;
    if (acc) begin
      dropped_next = 1'b0;
      case (func)
        FUNC_PUT: begin
          if (char_code == CH_LF) begin
            if (lf_scroll) begin
              cur_row_next = last_row;
              cmd.start    = 1'b1;
              cmd.scroll   = 1'b1;
            end else begin
              cur_row_next = RB'(row_s + span_t'(1));
            end
            cur_col_next = '0;
          end else if (char_code == CH_CR) begin
            cur_col_next = '0;
          end else if (printable) begin
            if (put_ok) begin
              put_we       = 1'b1;
              cur_col_next = CLW'(col_s + span_t'(1));
            end else begin
              dropped_next = 1'b1;
            end
          end
        end
        FUNC_MOVE: begin
          cur_row_next = RB'(trow_c);
          cur_col_next = CLW'(tcol_c);
        end
        FUNC_READ: begin
        end
        FUNC_CLEAR: begin
          cmd.start = 1'b1;
        end
        default: begin
        end
      endcase
    end
    // walked commands report when the walk ends; the pass after reset reports nothing
    done_next = (acc && !cmd.start) || (stat.finish && !init_pass);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RST;
      height_reg <= HEIGHT_RST;
      cur_row    <= '0;
      cur_col    <= '0;
      init_pass  <= 1'b1;
      done       <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_WIDTH) begin
        width_reg <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_HEIGHT) begin
        height_reg <= cfg_data[6:0];
      end
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      if (stat.finish) begin
        init_pass <= 1'b0;
      end
      done <= done_next;
    end
    dropped <= dropped_next;
    if (acc) begin
      rd_flag    <= (func == FUNC_READ);
      write_done <= end_of_text;
    end
  end

  // store port: the walker owns it while busy
  always_comb begin
    if (stat.active) begin
      ram_we    = sw_we;
      ram_waddr = sw_waddr;
      ram_wdata = sw_wdata;
      ram_raddr = sw_raddr;
    end else begin
      ram_we    = put_we;
      ram_waddr = {cur_row, cur_col[CB-1:0]};
      ram_wdata = char_code;
      ram_raddr = {RB'(trow_c), CB'(tcol_c)};
    end
  end

  tccw_sweep #(
    .ROW_W(RB),
    .COL_W(CB)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .last_row(last_row),
    .rdata   (ram_rdata),
    .stat    (stat),
    .we      (sw_we),
    .waddr   (sw_waddr),
    .wdata   (sw_wdata),
    .raddr   (sw_raddr)
  );

  tccw_ram #(
    .WIDTH(8),
    .DEPTH(1 << AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cursor_row = 6'(cur_row);
  assign cursor_col = 8'(cur_col);
  assign read_char  = (done && rd_flag) ? ram_rdata : 8'd0;

endmodule

@@ design/tccw_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module tccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tccw_sweep.sv @@
// Store walker: clearing pass and one-line scroll with read-modify-write pipelining.
`timescale 1ns / 1ps
module tccw_sweep
  import tccw_pkg::*;
#(
  parameter int ROW_W = 6,
  parameter int COL_W = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sweep_cmd_t               cmd,
  input  logic [ROW_W-1:0]         last_row,
  input  logic [7:0]               rdata,
  output sweep_stat_t              stat,
  output logic                     we,
  output logic [ROW_W+COL_W-1:0]   waddr,
  output logic [7:0]               wdata,
  output logic [ROW_W+COL_W-1:0]   raddr
);

  localparam int AW = ROW_W + COL_W;
  localparam logic [AW-1:0] ROW_STEP = AW'(1) << COL_W;

  sweep_state_t     state, state_next;
  logic [AW-1:0]    cnt, cnt_next;
  logic [ROW_W-1:0] row_last, row_last_next;
  logic             pend_valid, pend_valid_next;
  logic [AW-1:0]    pend_addr, pend_addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SW_CLEAR;
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
    end
    row_last  <= row_last_next;
    pend_addr <= pend_addr_next;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    row_last_next   = row_last;
    pend_valid_next = 1'b0;
    pend_addr_next  = pend_addr;
    stat.active     = (state != SW_IDLE);
    stat.finish     = 1'b0;
    raddr           = cnt + ROW_STEP;
    // a copied cell read last cycle takes the write port first
    we              = pend_valid;
    waddr           = pend_addr;
    wdata           = rdata;

    case (state)
      SW_IDLE: begin
        if (cmd.start) begin
          cnt_next      = '0;
          row_last_next = last_row;
          state_next    = cmd.scroll ? SW_COPY : SW_CLEAR;
        end
      end
      SW_CLEAR: begin
        we       = 1'b1;
        waddr    = cnt;
        wdata    = 8'd0;
        cnt_next = cnt + AW'(1);
        if (cnt == {AW{1'b1}}) begin
          stat.finish = 1'b1;
          state_next  = SW_IDLE;
        end
      end
      SW_COPY: begin
        if (cnt[AW-1:COL_W] == row_last) begin
          state_next = SW_BLANK;
        end else begin
          pend_valid_next = 1'b1;
          pend_addr_next  = cnt;
          cnt_next        = cnt + AW'(1);
        end
      end
      SW_BLANK: begin
        if (!pend_valid) begin
          we       = 1'b1;
          waddr    = cnt;
          wdata    = 8'd0;
          cnt_next = cnt + AW'(1);
          if (cnt[COL_W-1:0] == {COL_W{1'b1}}) begin
            stat.finish = 1'b1;
            state_next  = SW_IDLE;
          end
        end
      end
      default: begin
        state_next = SW_IDLE;
      end
    endcase
  end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the character-cell text window block.
`timescale 1ns / 1ps
module tb_top;
  import tccw_pkg::*;

  localparam int COLS        = 128;
  localparam int ROWS        = 64;
  localparam int STALL_LIMIT = 40000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 110;

  typedef struct packed {
    logic [5:0] cursor_row;
    logic [7:0] cursor_col;
    logic [7:0] read_char;
    logic       dropped;
    logic       write_done;
  } console_result_t;

  // Tracks the window contents and cursor, and holds the results still owed.
  class console_tracker;
    logic [7:0] width_reg;
    logic [6:0] height_reg;
    logic [5:0] row_q;
    logic [7:0] col_q;
    logic [7:0] cells [ROWS][COLS];
    console_result_t owed_q[$];
    int failures;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      row_q      = '0;
      col_q      = '0;
      failures   = 0;
      blank_all();
    endfunction

    function void blank_all();
      foreach (cells[r, c]) cells[r][c] = '0;
    endfunction

    function void load_window(logic [7:0] w, logic [7:0] h);
      width_reg  = w;
      height_reg = h[6:0];
    endfunction

    function int span(int value, int limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
    endfunction

    // Whole store lines move, so cells beyond the width travel with them.
    function void scroll_up(int h);
      for (int r = 0; r + 1 < h; r++)
        for (int c = 0; c < COLS; c++) cells[r][c] = cells[r + 1][c];
      for (int c = 0; c < COLS; c++) cells[h - 1][c] = '0;
    endfunction

    function void note_command(logic [1:0] f, logic [7:0] ch, logic [5:0] trow,
                               logic [6:0] tcol, logic eot);
      int w, h, r, c;
      console_result_t res;
      w   = span(int'(width_reg), COLS);
      h   = span(int'(height_reg), ROWS);
      r   = (int'(trow) >= h) ? h - 1 : int'(trow);
      c   = (int'(tcol) >= w) ? w - 1 : int'(tcol);
      res = '0;
      case (f)
        FUNC_PUT: begin
          if (ch == CH_LF) begin
            if (int'(row_q) + 1 >= h) begin
              scroll_up(h);
              row_q = 6'(h - 1);
            end else begin
              row_q = row_q + 6'd1;
            end
            col_q = '0;
          end else if (ch == CH_CR) begin
            col_q = '0;
          end else if (ch >= CH_FIRST && ch <= CH_LAST) begin
            if (int'(col_q) >= w || int'(row_q) >= h) begin
              res.dropped = 1'b1;
            end else begin
              cells[row_q][col_q] = ch;
              col_q = col_q + 8'd1;
            end
          end
        end
        FUNC_MOVE: begin
          row_q = 6'(r);
          col_q = 8'(c);
        end
        FUNC_READ: res.read_char = cells[r][c];
        default: blank_all();
      endcase
      res.cursor_row = row_q;
      res.cursor_col = col_q;
      res.write_done = eot;
      owed_q.push_back(res);
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_outcome(console_result_t got);
      console_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual %h", $time, got);
        failures++;
        return;
      end
      want = owed_q.pop_front();
      compare("cursor_row", want.cursor_row, got.cursor_row);
      compare("cursor_col", want.cursor_col, got.cursor_col);
      compare("read_char", want.read_char, got.read_char);
      compare("dropped", want.dropped, got.dropped);
      compare("write_done", want.write_done, got.write_done);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       start       = 1'b0;
  logic       busy;
  logic [1:0] func        = FUNC_READ;
  logic [7:0] char_code   = '0;
  logic [5:0] target_row  = '0;
  logic [6:0] target_col  = '0;
  logic       end_of_text = 1'b0;
  logic       cfg_we      = 1'b0;
  logic       cfg_index   = REG_WIDTH;
  logic [7:0] cfg_data    = '0;
  logic       done;
  logic [5:0] cursor_row;
  logic [7:0] cursor_col;
  logic [7:0] read_char;
  logic       dropped;
  logic       write_done;

  console_tracker tracker;
  bit pace_on = 1'b1;
  int phase_count;
  int stall_cycles = 0;

  text_console_cell_writer_top #(
    .MAX_COLS(COLS),
    .MAX_ROWS(ROWS)
  ) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .char_code(char_code), .target_row(target_row), .target_col(target_col),
    .end_of_text(end_of_text), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .cursor_row(cursor_row),
    .cursor_col(cursor_col), .read_char(read_char), .dropped(dropped),
    .write_done(write_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done)
      tracker.check_outcome({cursor_row, cursor_col, read_char, dropped, write_done});
  end

  // Count cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue(input logic [1:0] f, input logic [7:0] ch, input logic [5:0] trow,
                       input logic [6:0] tcol, input logic eot);
    while (pace_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    func        <= f;
    char_code   <= ch;
    target_row  <= trow;
    target_col  <= tcol;
    end_of_text <= eot;
    do @(posedge clk); while (busy);
    tracker.note_command(f, ch, trow, tcol, eot);
  endtask

  task automatic put_byte(input logic [7:0] ch, input logic eot);
    issue(FUNC_PUT, ch, 6'($urandom), 7'($urandom), eot);
  endtask

  // Hold off until every owed result has come and the block is idle.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0 || busy);
  endtask

  task automatic set_window(input logic [7:0] w, input logic [7:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.load_window(w, h);
  endtask

  function automatic logic [7:0] pick_width();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd128;
      2: return 8'($urandom_range(129, 255));
      default: return 8'($urandom_range(1, 128));
    endcase
  endfunction

  // Mostly short windows: a scroll costs about a store line per window row.
  function automatic logic [7:0] pick_height();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd64;
      2: return 8'($urandom_range(65, 255));
      3: return 8'($urandom_range(9, 64));
      default: return 8'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return 8'($urandom_range(CH_FIRST, CH_LAST));
    if (roll < 88) return CH_LF;
    if (roll < 94) return CH_CR;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_group();
    int pick, len;
    logic [7:0] ch;
    pick = $urandom_range(999);
    if (pick < 650) begin
      // one write call: a run of bytes, the last one flagged
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        ch = pick_byte();
        put_byte(ch, (i == len - 1) ? 1'b1 : 1'($urandom_range(15) == 0));
        if (ch == CH_LF || ch == CH_CR || (ch >= CH_FIRST && ch <= CH_LAST))
          phase_count++;
      end
    end else if (pick < 780) begin
      issue(FUNC_MOVE, 8'($urandom), 6'($urandom_range(63)), 7'($urandom_range(127)),
            1'($urandom_range(1)));
      phase_count++;
    end else if (pick < 995) begin
      if ($urandom_range(1))
        issue(FUNC_READ, 8'($urandom), tracker.row_q,
              7'($urandom_range(tracker.col_q > 0 ? tracker.col_q - 1 : 0)),
              1'($urandom_range(1)));
      else
        issue(FUNC_READ, 8'($urandom), 6'($urandom_range(63)), 7'($urandom_range(127)),
              1'($urandom_range(1)));
      phase_count++;
    end else begin
      issue(FUNC_CLEAR, 8'($urandom), 6'($urandom), 7'($urandom), 1'($urandom_range(1)));
      phase_count++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // wait out the clearing pass after reset
    do @(posedge clk); while (busy !== 1'b0);

    // Reset window of 80 by 24: printable extremes, ignored bytes, full row,
    // clamped move and read, scroll from the last row, clear.
    put_byte(8'h41, 1'b0);
    put_byte(CH_LAST, 1'b0);
    put_byte(CH_FIRST, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'h1F, 1'b0);
    put_byte(8'h7F, 1'b0);
    put_byte(8'hFF, 1'b1);
    issue(FUNC_READ, 8'h00, 6'd0, 7'd0, 1'b0);
    issue(FUNC_MOVE, 8'hFF, 6'd63, 7'd127, 1'b1);
    put_byte(8'h42, 1'b0);
    put_byte(8'h43, 1'b0);
    put_byte(CH_CR, 1'b0);
    put_byte(CH_LF, 1'b1);
    issue(FUNC_READ, 8'h00, 6'd22, 7'd79, 1'b0);
    issue(FUNC_CLEAR, 8'h00, 6'd0, 7'd0, 1'b1);
    issue(FUNC_READ, 8'h00, 6'd63, 7'd127, 1'b0);
    settle();

    // Zero width and height act as a single cell.
    set_window(8'd0, 8'd0);
    put_byte(8'h78, 1'b0);
    put_byte(8'h79, 1'b0);
    put_byte(CH_LF, 1'b1);
    issue(FUNC_READ, 8'h00, 6'd0, 7'd0, 1'b0);
    settle();

    // Oversized registers clamp to the full store.
    set_window(8'hFF, 8'hFF);
    issue(FUNC_MOVE, 8'h00, 6'd63, 7'd127, 1'b0);
    put_byte(8'h7A, 1'b0);
    put_byte(CH_LF, 1'b1);
    issue(FUNC_READ, 8'h00, 6'd62, 7'd127, 1'b0);
    settle();

    // Shrink under the cursor: a put is dropped, an LF scrolls to the last row.
    set_window(8'd4, 8'd2);
    put_byte(8'h71, 1'b0);
    put_byte(CH_LF, 1'b1);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      pace_on = (phase != 4);
      set_window(pick_width(), pick_height());
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) random_group();
      settle();
    end

    repeat (8) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
